/* rtl/core/iepa_pkg.sv */
// ----------------------------------------------------------------------------
// Input event packet assembler package
// Event and sample types, event codes and tool bits shared by the core.
// ----------------------------------------------------------------------------
package iepa_pkg;

    localparam int EVENT_BITS  = 47;
    localparam int SAMPLE_BITS = 100;
    localparam int S_DATA_BITS = ((EVENT_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

    localparam logic [4:0] EVT_SYN = 5'd0;
    localparam logic [4:0] EVT_KEY = 5'd1;
    localparam logic [4:0] EVT_ABS = 5'd3;

    localparam logic [9:0] SYNC_REPORT  = 10'd0;
    localparam logic [9:0] SYNC_DROPPED = 10'd3;

    localparam logic [9:0] AXIS_X           = 10'd0;
    localparam logic [9:0] AXIS_Y           = 10'd1;
    localparam logic [9:0] AXIS_PRESSURE    = 10'd24;
    localparam logic [9:0] AXIS_MT_SLOT     = 10'd47;
    localparam logic [9:0] AXIS_MT_POS_X    = 10'd53;
    localparam logic [9:0] AXIS_MT_POS_Y    = 10'd54;
    localparam logic [9:0] AXIS_MT_TRACK_ID = 10'd57;

    localparam logic [9:0] KEY_PEN_TOOL    = 10'd320;
    localparam logic [9:0] KEY_RUBBER_TOOL = 10'd321;
    localparam logic [9:0] KEY_TIP_TOUCH   = 10'd330;

    localparam logic [3:0] TOOL_PEN    = 4'd1;
    localparam logic [3:0] TOOL_RUBBER = 4'd2;
    localparam logic [3:0] TOOL_TOUCH  = 4'd4;
    localparam logic [3:0] TOOL_FINGER = 4'd8;

    localparam logic [31:0] NO_CONTACT = 32'hFFFF_FFFF;

    typedef struct packed {
        logic signed [31:0] event_value;
        logic [9:0]         event_code;
        logic [4:0]         event_type;
    } event_t;

    typedef struct packed {
        logic [3:0]         tool_mask;
        logic signed [31:0] pen_pressure;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_x;
    } sample_t;

endpackage

/* rtl/core/input_event_packet_assembler.sv */
// ----------------------------------------------------------------------------
// Input event packet assembler
// Folds an input event stream into pen samples, one per sync report.
// ----------------------------------------------------------------------------
// The slave channel takes one input event per word: type, code and signed
// value. Key and absolute-axis events update sticky x, y, pressure and a tool
// mask; a protocol B multitouch stream is reduced to the first contact that
// goes down. Each sync report produces one sample word on the master
// channel, except the report that closes a packet torn by a dropped-events
// sync, which is swallowed.
// An accepted event is held in the input register and is folded at the edge
// on which it advances; its sample is valid on the master side in the cycle
// after that edge. One event is accepted per cycle, limited only by the single
// output register: a report that makes a sample can move on only when that
// register is empty or being emptied in the same cycle. Events that make no
// sample never wait. If the receiver stalls, the sample holds, and the next
// such report waits in the input register with s_tready low.
// Reset clears all state: positions and pressure to zero, no tools, slot
// zero, no contact followed, no torn packet, both channels empty.
// ----------------------------------------------------------------------------
module input_event_packet_assembler (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // event_type[4:0], event_code[14:5], event_value[46:15], zero pad
    input  logic [iepa_pkg::S_DATA_BITS-1:0]  s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // pos_x[31:0], pos_y[63:32], pen_pressure[95:64], tool_mask[99:96], pad
    output logic [iepa_pkg::M_DATA_BITS-1:0]  m_tdata
);
    import iepa_pkg::*;

    logic    stage_valid_reg, stage_valid_next;
    event_t  stage_event_reg;
    logic    out_valid_reg, out_valid_next;
    sample_t out_sample_reg;
    logic    out_free;
    logic    advance;
    logic    emit;
    sample_t sample;

    iepa_fold u_fold (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ev_valid (stage_valid_reg),
        .ev_take  (advance),
        .ev       (stage_event_reg),
        .emit     (emit),
        .sample   (sample)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = stage_valid_reg && (!emit || out_free);
    assign s_tready = !stage_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_BITS - SAMPLE_BITS){1'b0}}, out_sample_reg};

    always_comb begin
        stage_valid_next = stage_valid_reg;
        if (s_tready) begin
            stage_valid_next = s_tvalid;
        end
        out_valid_next = out_valid_reg;
        if (advance && emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            stage_event_reg <= s_tdata[EVENT_BITS-1:0];
        end
        if (advance && emit) begin
            out_sample_reg <= sample;
        end
    end

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && emit |-> out_free)
        else $error("sample overwrites a pending word");

    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        stage_valid_reg && !advance |=> stage_valid_reg && $stable(stage_event_reg))
        else $error("stalled event lost");

    a_report_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        stage_valid_reg && !emit |-> advance)
        else $error("non-reporting event stalled");

endmodule

/* rtl/core/iepa_fold.sv */
// ----------------------------------------------------------------------------
// Input event packet assembler: event fold
// Holds the sticky pen and contact state and folds one event into it.
// ----------------------------------------------------------------------------
module iepa_fold (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             ev_valid,
    input  logic             ev_take,
    input  iepa_pkg::event_t ev,
    output logic             emit,
    output iepa_pkg::sample_t sample
);
    import iepa_pkg::*;

    logic signed [31:0] held_x_reg, held_x_next;
    logic signed [31:0] held_y_reg, held_y_next;
    logic signed [31:0] held_pressure_reg, held_pressure_next;
    logic [3:0]         held_tools_reg, held_tools_next;
    logic [31:0]        current_slot_reg, current_slot_next;
    logic [31:0]        followed_slot_reg, followed_slot_next;
    logic               torn_reg, torn_next;
    logic               slot_match;
    logic [3:0]         key_bit;

    assign slot_match = (current_slot_reg == followed_slot_reg);

    assign emit = ev_valid && (ev.event_type == EVT_SYN)
                  && (ev.event_code == SYNC_REPORT) && !torn_reg;

    assign sample.pos_x        = held_x_reg;
    assign sample.pos_y        = held_y_reg;
    assign sample.pen_pressure = held_pressure_reg;
    assign sample.tool_mask    = held_tools_reg;

    always_comb begin
        case (ev.event_code)
            KEY_PEN_TOOL:    key_bit = TOOL_PEN;
            KEY_RUBBER_TOOL: key_bit = TOOL_RUBBER;
            KEY_TIP_TOUCH:   key_bit = TOOL_TOUCH;
            default:         key_bit = 4'd0;
        endcase
    end

    always_comb begin
        held_x_next        = held_x_reg;
        held_y_next        = held_y_reg;
        held_pressure_next = held_pressure_reg;
        held_tools_next    = held_tools_reg;
        current_slot_next  = current_slot_reg;
        followed_slot_next = followed_slot_reg;
        torn_next          = torn_reg;
        case (ev.event_type)
            EVT_SYN: begin
                if (ev.event_code == SYNC_DROPPED) begin
                    torn_next = 1'b1;
                end else if (ev.event_code == SYNC_REPORT) begin
                    torn_next = 1'b0;
                end
            end
            EVT_KEY: begin
                if (ev.event_value != 32'sd0) begin
                    held_tools_next = held_tools_reg | key_bit;
                end else begin
                    held_tools_next = held_tools_reg & ~key_bit;
                end
            end
            EVT_ABS: begin
                case (ev.event_code)
                    AXIS_X:        held_x_next = ev.event_value;
                    AXIS_Y:        held_y_next = ev.event_value;
                    AXIS_PRESSURE: held_pressure_next = ev.event_value;
                    AXIS_MT_SLOT:  current_slot_next = ev.event_value;
                    AXIS_MT_TRACK_ID: begin
                        if (!ev.event_value[31]) begin
                            if (followed_slot_reg[31]) begin
                                followed_slot_next = current_slot_reg;
                                held_tools_next    = held_tools_reg | TOOL_FINGER;
                            end
                        end else if (slot_match) begin
                            followed_slot_next = NO_CONTACT;
                            held_tools_next    = held_tools_reg & ~TOOL_FINGER;
                        end
                    end
                    AXIS_MT_POS_X: begin
                        if (slot_match) begin
                            held_x_next = ev.event_value;
                        end
                    end
                    AXIS_MT_POS_Y: begin
                        if (slot_match) begin
                            held_y_next = ev.event_value;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_x_reg        <= '0;
            held_y_reg        <= '0;
            held_pressure_reg <= '0;
            held_tools_reg    <= '0;
            current_slot_reg  <= '0;
            followed_slot_reg <= NO_CONTACT;
            torn_reg          <= 1'b0;
        end else if (ev_take) begin
            held_x_reg        <= held_x_next;
            held_y_reg        <= held_y_next;
            held_pressure_reg <= held_pressure_next;
            held_tools_reg    <= held_tools_next;
            current_slot_reg  <= current_slot_next;
            followed_slot_reg <= followed_slot_next;
            torn_reg          <= torn_next;
        end
    end

    // A followed contact always carries the finger bit.
    a_follow_finger: assert property (@(posedge aclk) disable iff (!aresetn)
        !followed_slot_reg[31] |-> held_tools_reg[3])
        else $error("followed contact without finger bit");

    a_torn_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        ev_take && torn_reg && (ev.event_type == EVT_SYN)
        && (ev.event_code == SYNC_REPORT) |=> !torn_reg)
        else $error("torn packet not cleared by report");

    a_torn_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        torn_reg |-> !emit)
        else $error("sample emitted from torn packet");

endmodule

/* sim/tb_input_event_packet_assembler.sv */
// ----------------------------------------------------------------------------
// Input event packet assembler testbench
// Sends evdev-style event words (pen packets, protocol B multitouch packets,
// dropped-event syncs and noise) and checks each sample word against a
// predicted copy of the pen state. Both channels are stalled at random in the
// first two runs and not in the last.
module tb_input_event_packet_assembler;
    timeunit 1ns;
    timeprecision 1ps;

    import iepa_pkg::*;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_DATA_BITS-1:0] s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_DATA_BITS-1:0] m_tdata;

    input_event_packet_assembler dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    event_t  queued_events[$];
    sample_t expected_samples[$];

    int   send_idle_pct = 7;
    int   recv_idle_pct = 48;
    logic hold_start = 1'b0;
    logic rx_hold = 1'b0;
    int   failures = 0;
    int   items_queued = 0;

    logic signed [31:0] held_x = '0;
    logic signed [31:0] held_y = '0;
    logic signed [31:0] held_pressure = '0;
    logic [3:0]         held_tools = '0;
    logic [31:0]        current_slot = '0;
    logic [31:0]        followed_slot = NO_CONTACT;
    logic               torn_packet = 1'b0;

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    task automatic fold_event(input event_t ev);
        sample_t    smp;
        logic [3:0] tool_bit;
        logic [31:0] v;
        v = ev.event_value;
        tool_bit = '0;
        case (ev.event_type)
            EVT_SYN: begin
                if (ev.event_code == SYNC_DROPPED) begin
                    torn_packet = 1'b1;
                end else if (ev.event_code == SYNC_REPORT) begin
                    if (torn_packet) begin
                        torn_packet = 1'b0;
                    end else begin
                        smp.pos_x        = held_x;
                        smp.pos_y        = held_y;
                        smp.pen_pressure = held_pressure;
                        smp.tool_mask    = held_tools;
                        expected_samples.push_back(smp);
                    end
                end
            end
            EVT_ABS: begin
                case (ev.event_code)
                    AXIS_X:        held_x = v;
                    AXIS_Y:        held_y = v;
                    AXIS_PRESSURE: held_pressure = v;
                    AXIS_MT_SLOT:  current_slot = v;
                    AXIS_MT_TRACK_ID: begin
                        if (!v[31]) begin
                            if (followed_slot[31]) begin
                                followed_slot = current_slot;
                                held_tools |= TOOL_FINGER;
                            end
                        end else if (current_slot == followed_slot) begin
                            followed_slot = NO_CONTACT;
                            held_tools &= ~TOOL_FINGER;
                        end
                    end
                    AXIS_MT_POS_X: if (current_slot == followed_slot) held_x = v;
                    AXIS_MT_POS_Y: if (current_slot == followed_slot) held_y = v;
                    default: ;
                endcase
            end
            EVT_KEY: begin
                case (ev.event_code)
                    KEY_PEN_TOOL:    tool_bit = TOOL_PEN;
                    KEY_RUBBER_TOOL: tool_bit = TOOL_RUBBER;
                    KEY_TIP_TOUCH:   tool_bit = TOOL_TOUCH;
                    default:         tool_bit = '0;
                endcase
                if (v != 0) held_tools |= tool_bit;
                else held_tools &= ~tool_bit;
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) fold_event(event_t'(s_tdata[EVENT_BITS-1:0]));
            if (!s_tvalid || s_tready) begin
                if (queued_events.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= S_DATA_BITS'(queued_events.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        while (!hold_start) @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (300) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    always @(posedge aclk) begin
        sample_t got;
        sample_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = sample_t'(m_tdata[SAMPLE_BITS-1:0]);
            if (expected_samples.size() == 0) begin
                $error("unexpected sample word: x %0d y %0d p %0d tools %0h",
                       got.pos_x, got.pos_y, got.pen_pressure, got.tool_mask);
                failures++;
            end else begin
                want = expected_samples.pop_front();
                if (got.pos_x !== want.pos_x) begin
                    $error("pos_x: expected %0d, got %0d", want.pos_x, got.pos_x);
                    failures++;
                end
                if (got.pos_y !== want.pos_y) begin
                    $error("pos_y: expected %0d, got %0d", want.pos_y, got.pos_y);
                    failures++;
                end
                if (got.pen_pressure !== want.pen_pressure) begin
                    $error("pen_pressure: expected %0d, got %0d",
                           want.pen_pressure, got.pen_pressure);
                    failures++;
                end
                if (got.tool_mask !== want.tool_mask) begin
                    $error("tool_mask: expected %0h, got %0h", want.tool_mask, got.tool_mask);
                    failures++;
                end
            end
        end
    end

    task automatic add_event(input logic [4:0] typ, input logic [9:0] code,
                             input logic [31:0] value);
        event_t ev;
        ev.event_type  = typ;
        ev.event_code  = code;
        ev.event_value = value;
        queued_events.push_back(ev);
        items_queued++;
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(11))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h8000_0000;
            4, 5:    return $urandom_range(4095);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_slot();
        case ($urandom_range(9))
            0:       return 32'hFFFF_FFFF;
            1:       return $urandom;
            default: return $urandom_range(3);
        endcase
    endfunction

    function automatic logic [31:0] rand_track_id();
        case ($urandom_range(9))
            0, 1, 2, 3: return 32'hFFFF_FFFF;
            4:          return $urandom;
            default:    return $urandom_range(1000);
        endcase
    endfunction

    function automatic logic [31:0] rand_key_value();
        return $urandom_range(1) ? 32'h0 : rand_value();
    endfunction

    function automatic logic [9:0] rand_key_code();
        case ($urandom_range(2))
            0:       return KEY_PEN_TOOL;
            1:       return KEY_RUBBER_TOOL;
            default: return KEY_TIP_TOUCH;
        endcase
    endfunction

    task automatic add_pen_packet();
        if ($urandom_range(3) != 0) add_event(EVT_ABS, AXIS_X, rand_value());
        if ($urandom_range(3) != 0) add_event(EVT_ABS, AXIS_Y, rand_value());
        if ($urandom_range(1) != 0) add_event(EVT_ABS, AXIS_PRESSURE, rand_value());
        repeat ($urandom_range(2)) add_event(EVT_KEY, rand_key_code(), rand_key_value());
        add_event(EVT_SYN, SYNC_REPORT, $urandom_range(3) == 0 ? $urandom : 32'h0);
    endtask

    task automatic add_touch_packet();
        if ($urandom_range(2) == 0) add_event(EVT_ABS, AXIS_MT_SLOT, rand_slot());
        if ($urandom_range(2) != 0) add_event(EVT_ABS, AXIS_MT_TRACK_ID, rand_track_id());
        if ($urandom_range(3) != 0) add_event(EVT_ABS, AXIS_MT_POS_X, rand_value());
        if ($urandom_range(3) != 0) add_event(EVT_ABS, AXIS_MT_POS_Y, rand_value());
        add_event(EVT_SYN, SYNC_REPORT, 32'h0);
    endtask

    task automatic add_known_event();
        case ($urandom_range(8))
            0: add_event(EVT_ABS, AXIS_X, rand_value());
            1: add_event(EVT_ABS, AXIS_Y, rand_value());
            2: add_event(EVT_ABS, AXIS_PRESSURE, rand_value());
            3: add_event(EVT_ABS, AXIS_MT_SLOT, rand_slot());
            4: add_event(EVT_ABS, AXIS_MT_TRACK_ID, rand_track_id());
            5: add_event(EVT_ABS, AXIS_MT_POS_X, rand_value());
            6: add_event(EVT_ABS, AXIS_MT_POS_Y, rand_value());
            7: add_event(EVT_KEY, rand_key_code(), rand_key_value());
            default: add_event(EVT_SYN, $urandom_range(1) ? SYNC_REPORT : SYNC_DROPPED,
                               rand_value());
        endcase
    endtask

    task automatic add_random_events(input int count);
        int stop_at;
        int pick;
        stop_at = items_queued + count;
        while (items_queued < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                add_pen_packet();
            end else if (pick < 65) begin
                add_touch_packet();
            end else if (pick < 75) begin
                add_event(EVT_SYN, SYNC_DROPPED, rand_value());
                repeat ($urandom_range(3)) add_known_event();
                if ($urandom_range(3) != 0) add_event(EVT_SYN, SYNC_REPORT, 32'h0);
            end else if (pick < 90) begin
                add_known_event();
            end else begin
                add_event(5'($urandom_range(31)), 10'($urandom_range(767)), $urandom);
            end
        end
    endtask

    task automatic wait_drained();
        while (queued_events.size() != 0 || s_tvalid || expected_samples.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        add_event(EVT_ABS, AXIS_X, 32'h7FFF_FFFF);
        add_event(EVT_ABS, AXIS_Y, 32'h8000_0000);
        add_event(EVT_ABS, AXIS_PRESSURE, 32'hFFFF_FFFF);
        add_event(EVT_KEY, KEY_PEN_TOOL, 32'h0000_0001);
        add_event(EVT_KEY, KEY_RUBBER_TOOL, 32'h8000_0000);
        add_event(EVT_KEY, KEY_TIP_TOUCH, 32'h0000_0005);
        add_event(EVT_SYN, SYNC_REPORT, 32'h0);
        add_event(EVT_KEY, KEY_RUBBER_TOOL, 32'h0);
        add_event(5'd31, 10'd767, 32'hFFFF_FFFF);
        add_event(EVT_SYN, 10'd767, 32'h0);
        add_event(EVT_SYN, SYNC_DROPPED, 32'h0);
        add_event(EVT_SYN, SYNC_DROPPED, 32'h0);
        add_event(EVT_ABS, AXIS_X, 32'h0);
        add_event(EVT_SYN, SYNC_REPORT, 32'h0);
        add_event(EVT_SYN, SYNC_REPORT, 32'h0);
        add_event(EVT_ABS, AXIS_MT_SLOT, 32'd1);
        add_event(EVT_ABS, AXIS_MT_TRACK_ID, 32'd5);
        add_event(EVT_ABS, AXIS_MT_POS_X, 32'd100);
        add_event(EVT_ABS, AXIS_MT_SLOT, 32'd2);
        add_event(EVT_ABS, AXIS_MT_TRACK_ID, 32'd7);
        add_event(EVT_ABS, AXIS_MT_POS_Y, 32'd200);
        add_event(EVT_ABS, AXIS_MT_TRACK_ID, 32'hFFFF_FFFF);
        add_event(EVT_SYN, SYNC_REPORT, 32'h0);
        add_event(EVT_ABS, AXIS_MT_SLOT, 32'd1);
        add_event(EVT_ABS, AXIS_MT_TRACK_ID, 32'hFFFF_FFFF);
        add_event(EVT_ABS, AXIS_MT_SLOT, 32'hFFFF_FFFF);
        add_event(EVT_ABS, AXIS_MT_POS_X, 32'd300);
        add_event(EVT_ABS, AXIS_MT_TRACK_ID, 32'd9);
        add_event(EVT_SYN, SYNC_REPORT, 32'h0);
        add_random_events(250);
        wait_drained();

        @(negedge aclk);
        send_idle_pct = 48;
        recv_idle_pct = 7;
        hold_start    = 1'b1;
        add_random_events(260);
        wait_drained();

        @(negedge aclk);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random_events(260);
        wait_drained();
        repeat (20) @(posedge aclk);

        if (failures == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
